// ----- design/prf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Padding run finder package
// Shared types, codes and constants of the padding run finder.
// ----------------------------------------------------------------------------
package prf_pkg;

   // Command codes carried on the request tuser.
   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_FLUSH = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_MIN_SIZE     = 2'd0;
   localparam logic [1:0] CSR_MAX_CAVES    = 2'd1;
   localparam logic [1:0] CSR_SECTION_BASE = 2'd2;

   localparam logic [7:0]  PAD_CC     = 8'hCC;
   localparam logic [7:0]  PAD_ZERO   = 8'h00;
   localparam logic [31:0] ZERO_EXTRA = 32'd4;
   localparam logic [31:0] ZERO_TRIM  = 32'd2;
   localparam logic [20:0] MIN_LEGAL  = 21'd5;

   localparam logic [20:0] MIN_SIZE_RESET  = 21'd5;
   localparam logic [5:0]  MAX_CAVES_RESET = 6'd32;

   localparam int QUEUE_DEPTH = 4;

   // What the back end has to do with one word.
   typedef enum logic [2:0] {
      KIND_PAD_CC,
      KIND_PAD_ZERO,
      KIND_BREAK,
      KIND_FLUSH,
      KIND_END
   } prf_kind_type;

   typedef struct packed {
      prf_kind_type kind;
      logic [31:0]  byte_offset;
   } prf_item_type;

   typedef struct packed {
      logic [20:0] min_size;
      logic [5:0]  max_caves;
      logic [63:0] section_base;
   } prf_cfg_type;

endpackage

// ----- design/prf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Padding run finder front end
// Accepts request words and turns each, but for the unused command, into a work item for the back end.
// ----------------------------------------------------------------------------
module prf_front (
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_cmd,
   input  logic [7:0]           req_data_byte,
   input  logic [31:0]          req_byte_offset,
   input  logic                 queue_full,
   output logic                 push,
   output prf_pkg::prf_item_type push_item
);
   import prf_pkg::*;

   logic keep;

   assign req_tready = !queue_full;

   always_comb begin
      keep = 1'b1;
      push_item.byte_offset = req_byte_offset;
      push_item.kind = KIND_BREAK;
      unique case (req_cmd)
         CMD_DATA: begin
            if (req_data_byte == PAD_CC) begin
               push_item.kind = KIND_PAD_CC;
            end else if (req_data_byte == PAD_ZERO) begin
               push_item.kind = KIND_PAD_ZERO;
            end else begin
               push_item.kind = KIND_BREAK;
            end
         end
         CMD_FLUSH: push_item.kind = KIND_FLUSH;
         CMD_END:   push_item.kind = KIND_END;
         default:   keep = 1'b0;   // unused command has no effect
      endcase
   end

   assign push = req_tvalid && req_tready && keep;

endmodule

// ----- design/prf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Padding run finder queue
// Short first-in first-out queue of work items between front and back end.
// ----------------------------------------------------------------------------
module prf_queue #(
   parameter int DEPTH = prf_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  prf_pkg::prf_item_type push_item,
   output logic                 full,
   output logic                 head_valid,
   output prf_pkg::prf_item_type head_item,
   input  logic                 pop
);
   import prf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   prf_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/prf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Padding run finder back end
// Tracks the open padding run and registers a result when a run that meets the limits closes.
// ----------------------------------------------------------------------------
module prf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  prf_pkg::prf_cfg_type cfg,
   input  logic                 head_valid,
   input  prf_pkg::prf_item_type head_item,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_run_address,
   output logic [31:0]          rsp_run_length
);
   import prf_pkg::*;

   logic        in_run_ff, in_run_in;
   logic        zeros_only_ff, zeros_only_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] length_ff, length_in;
   logic [5:0]  count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] address_ff, address_in;
   logic [31:0] out_length_ff, out_length_in;

   logic        strict;
   logic        is_close;
   logic [31:0] need;
   logic        hit;
   logic [32:0] start_trim;

   assign pop = head_valid && (!out_valid_ff || rsp_tready);

   assign is_close = (head_item.kind == KIND_BREAK) || (head_item.kind == KIND_FLUSH)
                     || (head_item.kind == KIND_END);
   assign strict = (head_item.kind != KIND_FLUSH);
   assign need = (strict && zeros_only_ff) ? {11'd0, cfg.min_size} + ZERO_EXTRA
                                           : {11'd0, cfg.min_size};
   assign hit = pop && is_close && in_run_ff && (cfg.min_size >= MIN_LEGAL)
                && (count_ff < cfg.max_caves) && (length_ff >= need);
   assign start_trim = zeros_only_ff ? {1'b0, start_ff} + {1'b0, ZERO_TRIM}
                                     : {1'b0, start_ff};

   always_comb begin
      in_run_in = in_run_ff;
      zeros_only_in = zeros_only_ff;
      start_in = start_ff;
      length_in = length_ff;
      count_in = count_ff;
      address_in = address_ff;
      out_length_in = out_length_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (pop) begin
         unique case (head_item.kind)
            KIND_PAD_CC, KIND_PAD_ZERO: begin
               if (!in_run_ff) begin
                  in_run_in = 1'b1;
                  start_in = head_item.byte_offset;
                  length_in = 32'd1;
                  zeros_only_in = (head_item.kind == KIND_PAD_ZERO);
               end else begin
                  // The length holds once it reaches its top value.
                  if (length_ff != '1) begin
                     length_in = length_ff + 1'b1;
                  end
                  if (head_item.kind == KIND_PAD_CC) begin
                     zeros_only_in = 1'b0;
                  end
               end
            end
            KIND_BREAK, KIND_FLUSH, KIND_END: begin
               in_run_in = 1'b0;
               length_in = '0;
               if (hit) begin
                  out_valid_in = 1'b1;
                  address_in = cfg.section_base + {31'd0, start_trim};
                  out_length_in = zeros_only_ff ? length_ff - ZERO_EXTRA : length_ff;
                  count_in = count_ff + 1'b1;
               end
               if (head_item.kind == KIND_END) begin
                  zeros_only_in = 1'b0;
                  start_in = '0;
                  count_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
         zeros_only_ff <= 1'b0;
         start_ff <= '0;
         length_ff <= '0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_run_ff <= in_run_in;
         zeros_only_ff <= zeros_only_in;
         start_ff <= start_in;
         length_ff <= length_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
      out_length_ff <= out_length_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_run_address = address_ff;
   assign rsp_run_length = out_length_ff;

endmodule

// ----- design/padding_run_finder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Padding run finder
// Finds runs of 0xCC and 0x00 bytes in a section byte stream.
// ----------------------------------------------------------------------------
// The core takes one word per clock cycle while its work queue has room; the
// word that closes a run passes the queue before the run is registered.
// A small work queue sits between the word classifier and the run tracker,
// so a stalled result channel holds the tracker while up to QUEUE_DEPTH
// words are still taken in; the single result register then sets the pace,
// one word per cycle whenever results are taken as they come.
module padding_run_finder_core #(
   parameter int QUEUE_DEPTH = prf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte [7:0], byte_offset [39:8]
   input  logic [1:0]  req_tuser,   // cmd [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // run_address [63:0], run_length [95:64]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import prf_pkg::*;

   prf_cfg_type  cfg_ff, cfg_in;
   logic         push;
   prf_item_type push_item;
   logic         queue_full;
   logic         head_valid;
   prf_item_type head_item;
   logic         pop;
   logic [63:0]  run_address;
   logic [31:0]  run_length;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_SIZE:     cfg_in.min_size = csr_wdata[20:0];
            CSR_MAX_CAVES:    cfg_in.max_caves = csr_wdata[5:0];
            CSR_SECTION_BASE: cfg_in.section_base = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_size <= MIN_SIZE_RESET;
         cfg_ff.max_caves <= MAX_CAVES_RESET;
         cfg_ff.section_base <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prf_front u_front (
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_cmd         (req_tuser),
      .req_data_byte   (req_tdata[7:0]),
      .req_byte_offset (req_tdata[39:8]),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   prf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   prf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_run_address (run_address),
      .rsp_run_length  (run_length)
   );

   assign rsp_tdata = {run_length, run_address};

endmodule

// ----- dv/padding_run_finder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Padding run finder core testbench
// Streams section bytes, end-of-section and unreadable-chunk words into the
// core under random idling on both channels. A run tracker kept alongside
// the core works out each reported run, and every word on the result
// channel is compared with the oldest run still outstanding.
// ----------------------------------------------------------------------------
module padding_run_finder_core_tb;
   import prf_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         RANDOM_WORDS  = 1100;

   typedef struct packed {
      logic [63:0] address;
      logic [31:0] length;
   } run_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // data_byte [7:0], byte_offset [39:8]
   logic [1:0]  req_tuser  = CMD_DATA;   // cmd [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // run_address [63:0], run_length [95:64]
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_MIN_SIZE;
   logic [63:0] csr_wdata  = '0;

   // Configuration and run state as the tracker sees them.
   logic [20:0] cfg_min_size     = MIN_SIZE_RESET;
   logic [5:0]  cfg_max_caves    = MAX_CAVES_RESET;
   logic [63:0] cfg_section_base = '0;
   logic        trk_in_run       = 1'b0;
   logic        trk_zeros_only   = 1'b0;
   logic [31:0] trk_start        = '0;
   logic [31:0] trk_length       = '0;
   logic [5:0]  trk_reported     = '0;

   run_type     expected_runs[$];
   int          errors         = 0;
   int          words_sent     = 0;
   int          rsp_stall_left = 0;
   bit          gaps_on        = 1'b1;
   bit          stalls_on      = 1'b1;
   logic [31:0] cursor         = '0;

   always #10 clock = ~clock;

   padding_run_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Closes the open run. The strict test asks min_size+4 of a zero-only run.
   function automatic void close_open_run(input bit strict);
      logic [31:0] need;
      run_type     run;
      need = 32'(cfg_min_size);
      if (strict && trk_zeros_only) need = 32'(cfg_min_size) + ZERO_EXTRA;
      if (trk_in_run && cfg_min_size >= MIN_LEGAL && trk_reported < cfg_max_caves &&
          trk_length >= need) begin
         run.address = cfg_section_base + 64'(trk_start);
         run.length  = trk_length;
         if (trk_zeros_only) begin
            run.address = run.address + 64'(ZERO_TRIM);
            run.length  = trk_length - ZERO_EXTRA;
         end
         expected_runs.push_back(run);
         trk_reported = trk_reported + 6'd1;
      end
      trk_in_run = 1'b0;
      trk_length = '0;
   endfunction

   function automatic void track_word(input logic [1:0] cmd, input logic [7:0] data_byte,
                                      input logic [31:0] offset);
      case (cmd)
         CMD_DATA: begin
            if (data_byte == PAD_CC || data_byte == PAD_ZERO) begin
               if (!trk_in_run) begin
                  trk_in_run     = 1'b1;
                  trk_start      = offset;
                  trk_length     = 32'd1;
                  trk_zeros_only = (data_byte == PAD_ZERO);
               end else begin
                  if (trk_length != 32'hFFFF_FFFF) trk_length = trk_length + 32'd1;
                  if (data_byte == PAD_CC) trk_zeros_only = 1'b0;
               end
            end else begin
               close_open_run(1'b1);
            end
         end
         CMD_FLUSH: close_open_run(1'b0);
         CMD_END: begin
            close_open_run(1'b1);
            trk_zeros_only = 1'b0;
            trk_start      = '0;
            trk_reported   = '0;
         end
         default: ;
      endcase
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_break_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == PAD_CC);
      return b;
   endfunction

   task automatic send_word(input logic [1:0] cmd, input logic [7:0] data_byte,
                            input logic [31:0] offset);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {offset, data_byte};
      do @(posedge clock); while (!req_tready);
      track_word(cmd, data_byte, offset);
      if (cmd != CMD_UNUSED) words_sent++;
      gap = gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender until every outstanding run has come back and the
   // core has had time to work off words that give no run.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_MIN_SIZE:     cfg_min_size     = value[20:0];
         CSR_MAX_CAVES:    cfg_max_caves    = value[5:0];
         CSR_SECTION_BASE: cfg_section_base = value;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [20:0] min_size, input logic [5:0] max_caves,
                            input logic [63:0] section_base);
      wait_idle();
      write_csr(CSR_MIN_SIZE, 64'(min_size));
      write_csr(CSR_MAX_CAVES, 64'(max_caves));
      write_csr(CSR_SECTION_BASE, section_base);
   endtask

   // One padding run with random content and a random way of ending it, or
   // now and then a stray word.
   task automatic send_segment();
      int         roll;
      int         len;
      int         kind;
      int         base_len;
      logic [7:0] b;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 2))
            0: begin
               send_word(CMD_DATA, 8'($urandom), cursor);
               cursor++;
            end
            1: send_word(CMD_FLUSH, 8'($urandom), 32'($urandom));
            default: send_word(CMD_UNUSED, 8'($urandom), 32'($urandom));
         endcase
      end else begin
         base_len = (cfg_min_size >= MIN_LEGAL && cfg_min_size <= 21'd16) ?
                    int'(cfg_min_size) : 6;
         roll = $urandom_range(0, 99);
         if (roll < 20) len = $urandom_range(1, 4);
         else if (roll < 90) len = $urandom_range(base_len - 3, base_len + 8);
         else len = $urandom_range(20, 60);
         roll = $urandom_range(0, 99);
         kind = (roll < 30) ? 0 : (roll < 65) ? 1 : (roll < 85) ? 2 : 3;
         for (int i = 0; i < len; i++) begin
            case (kind)
               0: b = PAD_CC;
               1: b = PAD_ZERO;
               2: b = $urandom_range(0, 1) ? PAD_CC : PAD_ZERO;
               default: b = (i == len - 1) ? PAD_CC : PAD_ZERO;
            endcase
            send_word(CMD_DATA, b, cursor);
            cursor++;
         end
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            send_word(CMD_DATA, pick_break_byte(), cursor);
            cursor++;
         end else if (roll < 80) begin
            send_word(CMD_FLUSH, 8'($urandom), 32'($urandom));
         end else begin
            send_word(CMD_END, 8'($urandom), 32'($urandom));
            cursor = 32'($urandom);
         end
         if ($urandom_range(0, 9) == 0) cursor = 32'($urandom);
      end
   endtask

   task automatic run_traffic(input int count);
      int target;
      target = words_sent + count;
      while (words_sent < target) send_segment();
   endtask

   task automatic test_directed();
      // A mixed run of five closed by a plain byte is reported whole.
      send_word(CMD_DATA, PAD_CC, 32'd0);
      send_word(CMD_DATA, PAD_ZERO, 32'd1);
      send_word(CMD_DATA, PAD_ZERO, 32'd2);
      send_word(CMD_DATA, PAD_CC, 32'd3);
      send_word(CMD_DATA, PAD_ZERO, 32'd4);
      send_word(CMD_DATA, 8'hFF, 32'd5);
      // A zero-only run of nine closed by the end of the section is trimmed.
      for (int i = 0; i < 9; i++) send_word(CMD_DATA, PAD_ZERO, 32'h100 + 32'(i));
      send_word(CMD_END, 8'h00, 32'h0);
      // A flush takes a zero-only run of five under the plain test.
      for (int i = 0; i < 5; i++) send_word(CMD_DATA, PAD_ZERO, 32'hFFFF_FFFB + 32'(i));
      send_word(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF);
      // Neither a flush with no open run nor the unused command does anything.
      send_word(CMD_FLUSH, 8'h00, 32'h0);
      send_word(CMD_UNUSED, PAD_CC, 32'hFFFF_FFFF);
   endtask

   task automatic test_report_limit();
      configure(21'd5, 6'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      run_traffic(120);
      configure(21'd6, 6'd2, 64'hFFFF_FFFF_FFFF_FF00);
      run_traffic(80);
   endtask

   task automatic test_illegal_settings();
      configure(21'd4, 6'd32, {32'($urandom), 32'($urandom)});
      run_traffic(60);
      configure(21'd0, 6'd32, 64'h0);
      run_traffic(30);
      configure(21'd6, 6'd0, {32'($urandom), 32'($urandom)});
      run_traffic(50);
   endtask

   task automatic test_huge_minimum();
      configure(21'd1048576, 6'd32, {32'($urandom), 32'($urandom)});
      run_traffic(60);
   endtask

   task automatic test_back_to_back();
      wait_idle();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      configure(21'($urandom_range(5, 8)), 6'd32, {32'($urandom), 32'($urandom)});
      run_traffic(150);
      wait_idle();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_random_settings();
      while (words_sent < RANDOM_WORDS + 25) begin
         configure(21'($urandom_range(5, 12)), 6'($urandom_range(1, 32)),
                   {32'($urandom), 32'($urandom)});
         run_traffic(150);
      end
   endtask

   // Result channel back pressure.
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
                                                        $urandom_range(0, 2);
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      run_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: run expected none actual address %h length %h", $time,
                     rsp_tdata[63:0], rsp_tdata[95:64]);
            errors++;
         end else begin
            want = expected_runs.pop_front();
            if (rsp_tdata[63:0] !== want.address) begin
               $display("%0t: run_address expected %h actual %h", $time,
                        want.address, rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[95:64] !== want.length) begin
               $display("%0t: run_length expected %h actual %h", $time,
                        want.length, rsp_tdata[95:64]);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_report_limit();
      test_illegal_settings();
      test_huge_minimum();
      test_back_to_back();
      test_random_settings();
      wait_idle();
      if (errors == 0) begin
         $display("padding_run_finder_core regression: pass");
      end else begin
         $display("padding_run_finder_core regression: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("padding_run_finder_core regression: fail");
      $finish;
   end

endmodule
